// ----- rtl/core/ttti_pkg.sv -----
// Package for the turntable track index table: commands, widths, sequencer states.
package ttti_pkg;
  localparam int TRACKS_DEF    = 24;
  localparam int POSITIONS_DEF = 48;
  localparam int CMD_W   = 4;
  localparam int TRACK_W = 5;
  localparam int PLACE_W = 6;
  localparam int SENS_W  = 16;

  typedef enum logic [3:0] {
    CMD_CLEAR      = 4'd0,
    CMD_SET_FIRST  = 4'd1,
    CMD_ASSIGN     = 4'd2,
    CMD_REMOVE     = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_SET_SENSOR = 4'd5,
    CMD_CLEAR_REST = 4'd6,
    CMD_QUERY      = 4'd7,
    CMD_AT_PLACE   = 4'd8,
    CMD_ACCESSIBLE = 4'd9,
    CMD_NEXT       = 4'd10
  } cmd_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_EXEC = 6'b000100,
    ST_SRCH = 6'b001000,
    ST_STAT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;
endpackage

// ----- rtl/core/turntable_track_index_table.sv -----
// Top level of the turntable track index table: command sequencer over a register table.
//
// channel | dir | tdata fields (low bit up)                              | tuser
// s_axis  | in  | command[3:0] track[8:4] place[14:9] sensor_number[30:15] | direction
// m_axis  | out | ok[0] found_track[5:1] track_place[11:6]
//         |     |   track_sensor[27:12] configured_count[32:28] first_free[37:33] | -
//
// A request goes through accept, a scan of every entry, execute, a count over every entry, result.
// Insert and remove shift one entry per cycle.
// Next search steps off the track's place, then checks every entry at each position in turn.
// Reset is synchronous and clears all entries.
// The input is not ready until the result has been taken on m_axis.
module turntable_track_index_table #(
  parameter int TRACKS    = ttti_pkg::TRACKS_DEF,
  parameter int POSITIONS = ttti_pkg::POSITIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // command, track, place, sensor_number, pad
  input  logic        s_axis_tuser,  // direction
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // ok, found_track, track_place, track_sensor,
                                     // configured_count, first_free, pad
);
  import ttti_pkg::*;

  localparam int IW = $clog2(TRACKS);
  localparam int HALF = POSITIONS / 2;

  logic [PLACE_W-1:0] place_table [TRACKS];
  logic [SENS_W-1:0]  sensor_table [TRACKS];

  state_t state;
  logic [CMD_W-1:0]   cmd;
  logic [TRACK_W-1:0] trk;
  logic [PLACE_W-1:0] plc;
  logic [SENS_W-1:0]  sens;
  logic               dir;
  logic [IW-1:0]      idx;
  logic [PLACE_W:0]   step;
  logic [PLACE_W-1:0] probe;
  // scan results
  logic               hit_p;      // some other track at plc
  logic [TRACK_W-1:0] at_p;       // lowest track at plc
  logic [TRACK_W-1:0] at_o;       // lowest track at opposite
  logic               ok;
  logic [TRACK_W-1:0] found;
  logic [TRACK_W-1:0] cnt;
  logic [TRACK_W-1:0] ffree;
  logic [TRACK_W-1:0] cur_t;

  logic               trk_ok, plc_ok;
  logic [PLACE_W-1:0] opp, self_p, prev_p, next_p, last_p, e_place;
  logic [PLACE_W-1:0] probe_next;
  logic               last_idx;

  assign trk_ok = trk >= TRACK_W'(1) && trk <= TRACK_W'(TRACKS);
  assign plc_ok = plc >= PLACE_W'(1) && plc <= PLACE_W'(POSITIONS);
  assign opp = !plc_ok ? '0 : (plc <= PLACE_W'(HALF)) ? plc + PLACE_W'(HALF)
             : plc - PLACE_W'(HALF);
  assign self_p = trk_ok ? place_table[IW'(trk - 1'b1)] : '0;
  assign prev_p = (trk >= TRACK_W'(2) && trk <= TRACK_W'(TRACKS))
                ? place_table[IW'(trk - TRACK_W'(2))] : '0;
  assign next_p = self_p;
  assign last_p = place_table[TRACKS-1];
  assign e_place = place_table[idx];
  assign last_idx = idx == IW'(TRACKS - 1);
  assign cur_t = TRACK_W'(idx) + 1'b1;
  assign probe_next = dir ? ((probe <= PLACE_W'(1)) ? PLACE_W'(POSITIONS) : probe - 1'b1)
                          : ((probe >= PLACE_W'(POSITIONS)) ? PLACE_W'(1) : probe + 1'b1);

  assign s_axis_tready = state == ST_IDLE;
  assign m_axis_tvalid = state == ST_DONE;
  assign m_axis_tdata = {2'b00, ffree, cnt,
                         (trk_ok ? sensor_table[IW'(trk - 1'b1)] : SENS_W'(0)),
                         self_p, found, ok};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < TRACKS; i++) begin
        place_table[i]  <= '0;
        sensor_table[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          cmd  <= s_axis_tdata[3:0];
          trk  <= s_axis_tdata[8:4];
          plc  <= s_axis_tdata[14:9];
          sens <= s_axis_tdata[30:15];
          dir  <= s_axis_tuser;
          idx  <= '0;
          hit_p <= 1'b0;
          at_p <= '0;
          at_o <= '0;
          ok <= 1'b0;
          found <= '0;
          state <= ST_SCAN;
        end
        // one entry per cycle: occupancy of place and opposite
        ST_SCAN: begin
          if (e_place != '0 && e_place == plc && cur_t != trk) hit_p <= 1'b1;
          if (plc_ok && e_place == plc && at_p == '0) at_p <= cur_t;
          if (opp != '0 && e_place == opp && at_o == '0) at_o <= cur_t;
          if (last_idx) begin
            state <= ST_EXEC;
            idx <= '0;
          end else idx <= idx + 1'b1;
        end
        ST_EXEC: begin
          state <= ST_STAT;
          case (cmd)
            CMD_CLEAR: begin
              ok <= 1'b1;
              for (int i = 0; i < TRACKS; i++) begin
                place_table[i] <= '0;
                sensor_table[i] <= '0;
              end
            end
            CMD_SET_FIRST: begin
              ok <= 1'b1;
              place_table[0] <= PLACE_W'(1);
              sensor_table[0] <= '0;
            end
            CMD_ASSIGN: if (trk_ok && plc_ok && ((trk == TRACK_W'(1)) == (plc == PLACE_W'(1)))
                            && !hit_p && !(prev_p != '0 && plc <= prev_p)) begin
              ok <= 1'b1;
              place_table[IW'(trk - 1'b1)] <= plc;
            end
            CMD_REMOVE: if (trk_ok && trk != TRACK_W'(1) && self_p != '0) begin
              ok <= 1'b1;
              idx <= IW'(trk - 1'b1);
              state <= ST_SRCH;
            end
            CMD_INSERT: if (trk_ok && trk != TRACK_W'(1) && plc_ok && prev_p != '0
                            && last_p == '0 && !hit_p && plc > prev_p
                            && !(next_p != '0 && plc >= next_p)) begin
              ok <= 1'b1;
              idx <= IW'(TRACKS - 1);
              state <= ST_SRCH;
            end
            CMD_SET_SENSOR: if (trk_ok) begin
              ok <= 1'b1;
              sensor_table[IW'(trk - 1'b1)] <= sens;
            end
            CMD_CLEAR_REST: begin
              ok <= 1'b1;
              for (int i = 1; i < TRACKS; i++) begin
                place_table[i] <= '0;
                sensor_table[i] <= '0;
              end
            end
            CMD_QUERY: ok <= trk_ok;
            CMD_AT_PLACE: begin
              found <= at_p;
              ok <= at_p != '0;
            end
            CMD_ACCESSIBLE: begin
              found <= (at_p != '0) ? at_p : at_o;
              ok <= at_p != '0 || at_o != '0;
            end
            CMD_NEXT: if (trk_ok && self_p != '0) begin
              probe <= self_p;
              step <= '0;
              state <= ST_SRCH;
            end
            default: ;
          endcase
        end
        // shifts one entry per cycle, or next-track probe over all entries
        ST_SRCH: begin
          if (cmd == CMD_REMOVE) begin
            if (last_idx) begin
              place_table[idx] <= '0;
              sensor_table[idx] <= '0;
              idx <= '0;
              state <= ST_STAT;
            end else begin
              place_table[idx] <= place_table[IW'(idx + 1'b1)];
              sensor_table[idx] <= sensor_table[IW'(idx + 1'b1)];
              idx <= idx + 1'b1;
            end
          end else if (cmd == CMD_INSERT) begin
            if (idx == IW'(trk - 1'b1)) begin
              place_table[idx] <= plc;
              sensor_table[idx] <= sens;
              idx <= '0;
              state <= ST_STAT;
            end else begin
              place_table[idx] <= place_table[IW'(idx - 1'b1)];
              sensor_table[idx] <= sensor_table[IW'(idx - 1'b1)];
              idx <= idx - 1'b1;
            end
          end else begin
            // first cycle moves off the start; then all entries per position
            if (step == '0) begin
              probe <= probe_next;
              step <= (PLACE_W+1)'(1);
            end else if (e_place == probe) begin
              found <= cur_t;
              ok <= 1'b1;
              idx <= '0;
              state <= ST_STAT;
            end else if (last_idx) begin
              idx <= '0;
              if (step == (PLACE_W+1)'(POSITIONS)) state <= ST_STAT;
              else begin
                step <= step + 1'b1;
                probe <= probe_next;
              end
            end else idx <= idx + 1'b1;
          end
        end
        // count and first free, one entry per cycle
        ST_STAT: begin
          if (idx == '0) begin
            cnt <= (e_place != '0) ? TRACK_W'(1) : '0;
            ffree <= (e_place != '0) ? '0 : TRACK_W'(1);
          end else begin
            if (e_place != '0) cnt <= cnt + 1'b1;
            else if (ffree == '0) ffree <= cur_t;
          end
          if (last_idx) state <= ST_DONE;
          else idx <= idx + 1'b1;
        end
        ST_DONE: if (m_axis_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("in and out both open");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5:1] != '0 |-> m_axis_tdata[0]) else $error("found w/o ok");
endmodule

// ----- tb/ttti_checker.sv -----
// Checker for the turntable track index table: predicts each answer and compares it.
`timescale 1ns / 1ps

module ttti_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          errors,
  output int          pending,
  output int          answers_seen
);
  import ttti_pkg::*;

  localparam int NTRK = TRACKS_DEF;
  localparam int NPOS = POSITIONS_DEF;

  // fields from the low bit up: ok, found_track, track_place, track_sensor, count, first_free
  typedef struct packed {
    logic [4:0]  first_free;
    logic [4:0]  configured_count;
    logic [15:0] track_sensor;
    logic [5:0]  track_place;
    logic [4:0]  found_track;
    logic        ok;
  } answer_t;

  logic [5:0]  place_tab[1:NTRK];
  logic [15:0] sensor_tab[1:NTRK];
  answer_t     answer_q[$];

  function automatic bit track_valid(int t);
    return t >= 1 && t <= NTRK;
  endfunction

  function automatic bit place_valid(int p);
    return p >= 1 && p <= NPOS;
  endfunction

  function automatic int place_of_track(int t);
    return track_valid(t) ? int'(place_tab[t]) : 0;
  endfunction

  function automatic int track_holding(int p);
    if (!place_valid(p)) return 0;
    for (int t = 1; t <= NTRK; t++) if (place_tab[t] == p) return t;
    return 0;
  endfunction

  // place p is not taken by any track other than t
  function automatic bit place_open(int t, int p);
    for (int o = 1; o <= NTRK; o++)
      if (o != t && place_tab[o] != 0 && place_tab[o] == p) return 0;
    return 1;
  endfunction

  function automatic int next_around(int t, bit dir);
    int p;
    int f;
    if (!track_valid(t) || place_of_track(t) == 0) return 0;
    p = place_of_track(t);
    for (int k = 1; k <= NPOS; k++) begin
      if (!dir) p = (p >= NPOS) ? 1 : p + 1;
      else p = (p <= 1) ? NPOS : p - 1;
      f = track_holding(p);
      if (f != 0) return f;
    end
    return 0;
  endfunction

  // apply one request to the shadow table and build its answer
  function automatic answer_t apply_request(logic [3:0] code, int t, int p, int s, bit dir);
    answer_t a;
    bit ok;
    int found;
    int prev;
    int nxt;
    int cnt;
    int free;
    int tp;
    ok = 0;
    found = 0;
    case (code)
      CMD_CLEAR: begin
        for (int v = 1; v <= NTRK; v++) begin
          place_tab[v] = '0;
          sensor_tab[v] = '0;
        end
        ok = 1;
      end
      CMD_SET_FIRST: begin
        place_tab[1] = 6'd1;
        sensor_tab[1] = '0;
        ok = 1;
      end
      CMD_ASSIGN: begin
        ok = track_valid(t) && place_valid(p);
        if (ok && t == 1 && p != 1) ok = 0;
        if (ok && t != 1 && p == 1) ok = 0;
        if (ok && !place_open(t, p)) ok = 0;
        if (ok && t >= 2) begin
          prev = place_of_track(t - 1);
          if (prev != 0 && p <= prev) ok = 0;
        end
        if (ok) place_tab[t] = p[5:0];
      end
      CMD_REMOVE: begin
        ok = track_valid(t) && t != 1 && place_of_track(t) != 0;
        if (ok) begin
          for (int v = t; v < NTRK; v++) begin
            place_tab[v] = place_tab[v+1];
            sensor_tab[v] = sensor_tab[v+1];
          end
          place_tab[NTRK] = '0;
          sensor_tab[NTRK] = '0;
        end
      end
      CMD_INSERT: begin
        ok = track_valid(t) && t != 1 && place_valid(p);
        if (ok && place_of_track(t - 1) == 0) ok = 0;
        if (ok && place_of_track(NTRK) != 0) ok = 0;
        if (ok && !place_open(t, p)) ok = 0;
        if (ok) begin
          prev = place_of_track(t - 1);
          nxt = place_of_track(t);
          if (prev != 0 && p <= prev) ok = 0;
          if (nxt != 0 && p >= nxt) ok = 0;
        end
        if (ok) begin
          for (int v = NTRK; v > t; v--) begin
            place_tab[v] = place_tab[v-1];
            sensor_tab[v] = sensor_tab[v-1];
          end
          place_tab[t] = p[5:0];
          sensor_tab[t] = s[15:0];
        end
      end
      CMD_SET_SENSOR: begin
        ok = track_valid(t);
        if (ok) sensor_tab[t] = s[15:0];
      end
      CMD_CLEAR_REST: begin
        for (int v = 2; v <= NTRK; v++) begin
          place_tab[v] = '0;
          sensor_tab[v] = '0;
        end
        ok = 1;
      end
      CMD_QUERY: ok = track_valid(t);
      CMD_AT_PLACE: begin
        found = track_holding(p);
        ok = found != 0;
      end
      CMD_ACCESSIBLE: begin
        // direct place first, then the one half a turn away
        if (place_valid(p)) begin
          found = track_holding(p);
          if (found == 0) found = track_holding(p <= NPOS / 2 ? p + NPOS / 2 : p - NPOS / 2);
        end
        ok = found != 0;
      end
      CMD_NEXT: begin
        found = next_around(t, dir);
        ok = found != 0;
      end
      default: ok = 0;
    endcase
    cnt = 0;
    free = 0;
    for (int v = 1; v <= NTRK; v++) begin
      if (place_tab[v] != 0) cnt++;
      else if (free == 0) free = v;
    end
    tp = place_of_track(t);
    a.ok = ok;
    a.found_track = found[4:0];
    a.track_place = tp[5:0];
    a.track_sensor = track_valid(t) ? sensor_tab[t] : 16'd0;
    a.configured_count = cnt[4:0];
    a.first_free = free[4:0];
    return a;
  endfunction

  assign pending = answer_q.size();

  // predict on each accepted request, compare on each accepted answer
  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (rst) begin
      for (int v = 1; v <= NTRK; v++) begin
        place_tab[v] = '0;
        sensor_tab[v] = '0;
      end
      answer_q.delete();
      errors <= 0;
      answers_seen <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        answer_q.push_back(apply_request(s_axis_tdata[3:0], int'(s_axis_tdata[8:4]),
                                         int'(s_axis_tdata[14:9]),
                                         int'(s_axis_tdata[30:15]), s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        answers_seen <= answers_seen + 1;
        got = answer_t'(m_axis_tdata[37:0]);
        if (answer_q.size() == 0) begin
          $error("answer with no request outstanding: %h", m_axis_tdata);
          errors <= errors + 1;
        end else begin
          want = answer_q.pop_front();
          if (got != want) begin
            errors <= errors + 1;
            if (got.ok != want.ok)
              $error("ok: expected %0d, got %0d", want.ok, got.ok);
            if (got.found_track != want.found_track)
              $error("found_track: expected %0d, got %0d", want.found_track, got.found_track);
            if (got.track_place != want.track_place)
              $error("track_place: expected %0d, got %0d", want.track_place, got.track_place);
            if (got.track_sensor != want.track_sensor)
              $error("track_sensor: expected %0d, got %0d",
                     want.track_sensor, got.track_sensor);
            if (got.configured_count != want.configured_count)
              $error("configured_count: expected %0d, got %0d",
                     want.configured_count, got.configured_count);
            if (got.first_free != want.first_free)
              $error("first_free: expected %0d, got %0d", want.first_free, got.first_free);
          end
        end
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the turntable track index table: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_top;
  import ttti_pkg::*;

  localparam logic [3:0] CMD_UNKNOWN_LO = 4'd11;
  localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 1400;
  localparam int PHASE_ITEMS = 270;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // command, track, place, sensor_number, pad
  logic        s_axis_tuser = 0;    // direction
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;        // ok, found_track, track_place, track_sensor,
                                    // configured_count, first_free, pad
  int errors;
  int pending;
  int answers_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit holding = 0;
  int items_sent = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  turntable_track_index_table dut (.*);

  ttti_checker chk (.*);

  // cycle budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL turntable_track_index_table");
      $finish;
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else m_axis_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    forever begin
      wait (hold_req);
      holding = 1;
      repeat (600) @(posedge clk);
      holding = 0;
      hold_req = 0;
    end
  end

  task automatic send(logic [3:0] code, int t, int p, int s, bit dir);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, s[15:0], p[5:0], t[4:0], code};
    s_axis_tuser <= dir;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic int pick_track();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 0 : $urandom_range(25, 31);
    return $urandom_range(1, 24);
  endfunction

  function automatic int pick_place();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 0 : $urandom_range(49, 63);
    return $urandom_range(1, 48);
  endfunction

  // build an ordered table, then edit and query it; sometimes pure noise
  task automatic random_burst();
    int k;
    int pos;
    int t;
    if ($urandom_range(9) < 7) begin
      send(CMD_CLEAR, pick_track(), pick_place(), $urandom, $urandom_range(1));
      send(CMD_SET_FIRST, 1, 1, $urandom, $urandom_range(1));
      k = $urandom_range(2, 24);
      pos = 1;
      for (t = 2; t <= k; t++) begin
        pos += $urandom_range(1, 2);
        send(CMD_ASSIGN, t, pos, $urandom, $urandom_range(1));
      end
      repeat ($urandom_range(6, 14)) begin
        t = pick_track();
        case ($urandom_range(6))
          0: send(CMD_INSERT, t, 2 * t - 2 + $urandom_range(2), $urandom, 0);
          1: send(CMD_REMOVE, t, 0, 0, 0);
          2: send(CMD_SET_SENSOR, t, pick_place(), $urandom, $urandom_range(1));
          3: send(CMD_ACCESSIBLE, t, pick_place(), $urandom, $urandom_range(1));
          4: send(CMD_NEXT, t, pick_place(), $urandom, $urandom_range(1));
          5: send(CMD_AT_PLACE, t, pick_place(), 0, 0);
          default: send(CMD_ASSIGN, t, pick_place(), $urandom, 0);
        endcase
      end
    end else begin
      repeat (6)
        send(4'($urandom_range(15)), $urandom_range(31), $urandom_range(63), $urandom,
             $urandom_range(1));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty table, ordering rejections, shifts, lookups, unknown codes
    send(CMD_QUERY, 1, 0, 0, 0);
    send(CMD_NEXT, 1, 0, 0, 0);
    send(CMD_ASSIGN, 1, 5, 0, 0);
    send(CMD_SET_FIRST, 1, 0, 0, 0);
    send(CMD_ASSIGN, 2, 1, 0, 0);
    send(CMD_ASSIGN, 2, 5, 0, 0);
    send(CMD_ASSIGN, 3, 4, 0, 0);
    send(CMD_ASSIGN, 3, 48, 16'hFFFF, 1);
    send(CMD_INSERT, 3, 10, 16'hFFFF, 0);
    send(CMD_INSERT, 3, 48, 16'h1234, 0);
    send(CMD_INSERT, 1, 2, 0, 0);
    send(CMD_REMOVE, 1, 0, 0, 0);
    send(CMD_REMOVE, 2, 0, 0, 0);
    send(CMD_REMOVE, 20, 0, 0, 0);
    send(CMD_SET_SENSOR, 31, 63, 16'hFFFF, 1);
    send(CMD_SET_SENSOR, 24, 0, 16'hFFFF, 0);
    send(CMD_AT_PLACE, 0, 63, 0, 0);
    send(CMD_AT_PLACE, 0, 10, 0, 0);
    send(CMD_ACCESSIBLE, 2, 34, 0, 0);
    send(CMD_ACCESSIBLE, 2, 0, 0, 0);
    send(CMD_NEXT, 1, 0, 0, 0);
    send(CMD_NEXT, 1, 0, 0, 1);
    send(CMD_NEXT, 31, 0, 0, 1);
    send(CMD_UNKNOWN_LO, 2, 3, 0, 0);
    send(CMD_UNKNOWN_HI, 31, 63, 16'hFFFF, 1);
    send(CMD_CLEAR_REST, 2, 0, 0, 0);

    // pacing phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 60 : (ph == 3) ? 10 : 0;
      recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 10 : 0;
      if (ph == 1) hold_req = 1;
      if (ph == 2) begin
        s_axis_tvalid <= 0;
        wait (pending == 0);
      end
      begin
        int goal;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) random_burst();
      end
    end
    s_axis_tvalid <= 0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d answers checked): directed edge cases, then ordered",
             items_sent, answers_seen);
    $display("table builds with edits and lookups under four pacing mixes and a long stall.");
    if (errors == 0 && pending == 0) begin
      $display("PASS turntable_track_index_table");
    end else begin
      $display("FAIL turntable_track_index_table");
    end
    $finish;
  end
endmodule
